>>> rtl/dqip_pkg.sv
// Shared types and constants for the dotted-quad IPv4 parser.
// Holds the request structs of both channels and the error codes.
// No dependencies; used by dqip_core and dotted_quad_ipv4_parser.
package dqip_pkg;

  // One character of the string and its end-of-string mark.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_req_t;

  // One parse result.
  typedef struct packed {
    logic        parse_ok;
    logic [1:0]  error_kind;
    logic [31:0] ip_address;
  } out_req_t;

  // Error codes carried in error_kind.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SYNTAX    = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

  // Character codes and limits.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [8:0] OCTET_LIMIT = 9'd256;
  localparam logic [1:0] LAST_OCTET  = 2'd3;

endpackage

>>> rtl/dotted_quad_ipv4_parser.sv
// Top level of the dotted-quad IPv4 parser.
// Input register, output register and handshake around dqip_core.
// Depends on dqip_pkg and dqip_core.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one character
//   of the string per request; in_data.last_byte marks the final character.
//   The output channel (out_valid, out_stall, out_data) gives one result
//   request per string: parse_ok, error_kind and ip_address.
//   Throughput is one character per cycle while in_stall is low. A
//   character is held in the input register, where the parse state
//   machine consumes it, and the result is written into the output
//   register when the last character leaves the input register.
//   While the receiver stalls, a held result stays in the output register
//   and characters that produce no result keep flowing; only a last
//   character waiting on the full output register stalls the input.
//   Synchronous reset (rst_n low) empties both registers and returns the
//   parser to the start of a string; it takes characters as soon as rst_n is high.
module dotted_quad_ipv4_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dqip_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dqip_pkg::out_req_t out_data
);

  logic               s1_valid_r;
  dqip_pkg::in_req_t  s1_req_r;
  logic               s1_go;
  logic               out_valid_r;
  dqip_pkg::out_req_t out_data_r;
  dqip_pkg::out_req_t core_res;

  // The held character moves on unless it needs the output register and that is blocked.
  assign s1_go    = s1_valid_r && (!s1_req_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_data;
    end
  end

  // Parse state machine.
  dqip_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .req   (s1_req_r),
    .res   (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_req_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_req_r.last_byte) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The input only stalls while a character is held.
  a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // A success carries no error code.
  a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.parse_ok) |-> (out_data.error_kind == dqip_pkg::ERR_NONE))
    else $error("successful result with error code");

  // A failure carries an error code and a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.parse_ok) |->
      ((out_data.ip_address == '0) && (out_data.error_kind != dqip_pkg::ERR_NONE)))
    else $error("failed result with address or without error code");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> rtl/dqip_core.sv
// Parse state machine of the dotted-quad IPv4 parser.
// Updates the parse state by one character per step and forms the result.
// Depends on dqip_pkg.
module dqip_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  dqip_pkg::in_req_t req,
  output dqip_pkg::out_req_t res
);

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_DIGITS,
    MODE_DONE,
    MODE_FAIL
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] num_r, num_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic       too_large_r, too_large_nxt;
  logic [7:0] store_r [3];
  logic       store_we;

  logic        is_digit;
  logic        is_blank;
  logic [3:0]  digit;
  logic [11:0] acc_sum;
  logic [8:0]  acc_sat;
  logic        complete;

  // Character classes.
  assign is_digit = (req.char_byte >= dqip_pkg::CHAR_ZERO) &&
                    (req.char_byte <= dqip_pkg::CHAR_NINE);
  assign is_blank = (req.char_byte == dqip_pkg::CHAR_SPACE) ||
                    ((req.char_byte >= dqip_pkg::CHAR_TAB) &&
                     (req.char_byte <= dqip_pkg::CHAR_CR));
  assign digit = req.char_byte[3:0];

  // Multiply by ten as two shifts, add the digit, saturate at the octet limit.
  assign acc_sum = ({3'b000, acc_r} << 3) + ({3'b000, acc_r} << 1) + {8'h00, digit};
  assign acc_sat = (acc_sum >= {3'b000, dqip_pkg::OCTET_LIMIT}) ?
                   dqip_pkg::OCTET_LIMIT : acc_sum[8:0];

  // Next parse state for this character.
  always_comb begin
    mode_nxt      = mode_r;
    num_nxt       = num_r;
    acc_nxt       = acc_r;
    too_large_nxt = too_large_r;
    store_we      = 1'b0;
    case (mode_r)
      MODE_SKIP: begin
        if (is_digit) begin
          acc_nxt  = {5'b00000, digit};
          mode_nxt = MODE_DIGITS;
        end else if (!is_blank) begin
          mode_nxt = MODE_FAIL;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          acc_nxt = acc_sat;
        end else if (num_r == dqip_pkg::LAST_OCTET) begin
          mode_nxt = MODE_DONE;
        end else if (req.char_byte == dqip_pkg::CHAR_DOT) begin
          if (acc_r >= dqip_pkg::OCTET_LIMIT) begin
            too_large_nxt = 1'b1;
          end
          store_we = 1'b1;
          num_nxt  = num_r + 2'd1;
          acc_nxt  = '0;
          mode_nxt = MODE_SKIP;
        end else begin
          mode_nxt = MODE_FAIL;
        end
      end
      MODE_DONE: begin
        mode_nxt = MODE_DONE;
      end
      default: begin
        mode_nxt = MODE_FAIL;
      end
    endcase
  end

  // Result as seen after this character.
  assign complete = (mode_nxt == MODE_DONE) ||
                    ((mode_nxt == MODE_DIGITS) && (num_nxt == dqip_pkg::LAST_OCTET));

  always_comb begin
    res.parse_ok   = 1'b0;
    res.error_kind = dqip_pkg::ERR_SYNTAX;
    res.ip_address = '0;
    if (complete) begin
      if (too_large_nxt || (acc_nxt >= dqip_pkg::OCTET_LIMIT)) begin
        res.error_kind = dqip_pkg::ERR_TOO_LARGE;
      end else begin
        res.parse_ok   = 1'b1;
        res.error_kind = dqip_pkg::ERR_NONE;
        res.ip_address = {store_r[0], store_r[1], store_r[2], acc_nxt[7:0]};
      end
    end
  end

  // Parse state; the last character of a string returns it to the start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SKIP;
      num_r       <= '0;
      acc_r       <= '0;
      too_large_r <= 1'b0;
    end else if (step) begin
      if (req.last_byte) begin
        mode_r      <= MODE_SKIP;
        num_r       <= '0;
        acc_r       <= '0;
        too_large_r <= 1'b0;
      end else begin
        mode_r      <= mode_nxt;
        num_r       <= num_nxt;
        acc_r       <= acc_nxt;
        too_large_r <= too_large_nxt;
      end
    end
  end

  // Octets that were closed by a dot; read only once all three are written.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (step && store_we && (num_r == 2'(i))) begin
        store_r[i] <= acc_r[7:0];
      end
    end
  end

endmodule

>>> bench/dotted_quad_ipv4_parser_tb.sv
// Self-checking testbench for dotted_quad_ipv4_parser: byte strings in, parse results out.
// Depends on dqip_pkg and the parser RTL. A scoreboard class predicts each result
// from the accepted characters; tasks drive the input, a receiver block drives out_stall.
module dotted_quad_ipv4_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STIMULUS_CHARS = 930;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum logic [1:0] {SCAN_BLANKS, IN_NUMBER, COMPLETE, REJECTED} parse_phase_t;

  // Tracks the parse of the current string and queues the result it must produce.
  class address_tracker;
    parse_phase_t       phase;
    logic [1:0]         octet_idx;
    logic [8:0]         acc;
    logic [7:0]         octets [3];
    logic               oversize;
    dqip_pkg::out_req_t pending_results [$];
    int                 fault_count;

    function new();
      fault_count = 0;
      restart();
    endfunction

    function void restart();
      phase     = SCAN_BLANKS;
      octet_idx = '0;
      acc       = '0;
      oversize  = 1'b0;
      foreach (octets[k]) octets[k] = '0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= dqip_pkg::CHAR_ZERO && c <= dqip_pkg::CHAR_NINE;
    endfunction

    // Advance the parse by one accepted character request.
    function void take_char(dqip_pkg::in_req_t req);
      logic [7:0] c;
      int grown;
      dqip_pkg::out_req_t want;
      c = req.char_byte;
      case (phase)
        SCAN_BLANKS: begin
          if (is_digit(c)) begin
            acc   = 9'(c - dqip_pkg::CHAR_ZERO);
            phase = IN_NUMBER;
          end else if (!(c == dqip_pkg::CHAR_SPACE ||
                         (c >= dqip_pkg::CHAR_TAB && c <= dqip_pkg::CHAR_CR))) begin
            phase = REJECTED;
          end
        end
        IN_NUMBER: begin
          if (is_digit(c)) begin
            // The octet value saturates at the too-large mark.
            grown = int'(acc) * 10 + int'(c - dqip_pkg::CHAR_ZERO);
            acc   = (grown >= int'(dqip_pkg::OCTET_LIMIT)) ? dqip_pkg::OCTET_LIMIT
                                                          : 9'(grown);
          end else if (octet_idx == dqip_pkg::LAST_OCTET) begin
            phase = COMPLETE;
          end else if (c == dqip_pkg::CHAR_DOT) begin
            if (acc >= dqip_pkg::OCTET_LIMIT) oversize = 1'b1;
            octets[octet_idx] = acc[7:0];
            octet_idx = octet_idx + 2'd1;
            acc   = '0;
            phase = SCAN_BLANKS;
          end else begin
            phase = REJECTED;
          end
        end
        default: ;
      endcase

      if (req.last_byte) begin
        // Syntax must be complete before the too-large check applies.
        want = '{parse_ok: 1'b0, error_kind: dqip_pkg::ERR_SYNTAX, ip_address: '0};
        if (phase == COMPLETE ||
            (phase == IN_NUMBER && octet_idx == dqip_pkg::LAST_OCTET)) begin
          if (oversize || acc >= dqip_pkg::OCTET_LIMIT) begin
            want.error_kind = dqip_pkg::ERR_TOO_LARGE;
          end else begin
            want.parse_ok   = 1'b1;
            want.error_kind = dqip_pkg::ERR_NONE;
            want.ip_address = {octets[0], octets[1], octets[2], acc[7:0]};
          end
        end
        pending_results.push_back(want);
        restart();
      end
    endfunction

    // Compare one result request with the oldest prediction.
    function void match_result(dqip_pkg::out_req_t got);
      dqip_pkg::out_req_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h, no string pending", $time, got);
        fault_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.parse_ok !== want.parse_ok) begin
        $display("%0t: parse_ok expected %0b, actual %0b", $time, want.parse_ok, got.parse_ok);
        fault_count++;
      end
      if (got.error_kind !== want.error_kind) begin
        $display("%0t: error_kind expected %0d, actual %0d", $time,
                 want.error_kind, got.error_kind);
        fault_count++;
      end
      if (got.ip_address !== want.ip_address) begin
        $display("%0t: ip_address expected %h, actual %h", $time,
                 want.ip_address, got.ip_address);
        fault_count++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dqip_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dqip_pkg::out_req_t out_data;

  address_tracker tracker = new();
  logic [7:0] text [$];
  int  chars_sent = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;

  dotted_quad_ipv4_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Watch both channels, feed the scoreboard and catch a hung block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_char(in_data);
      if (out_valid && !out_stall) tracker.match_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? dqip_pkg::CHAR_SPACE : dqip_pkg::CHAR_TAB + 8'(k);
  endfunction

  // Offer one character request and hold it until accepted. Called at a falling edge.
  task automatic send_char(input logic [7:0] ch, input logic fin);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_byte: ch, last_byte: fin};
    do @(posedge clk); while (in_stall);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin : stimulus
    int roll;
    int value;
    int blank_run;
    string numeral;
    bit hold_fired;
    hold_fired = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings: octet extremes with saturation, whitespace where a dot
    // belongs, a string ending too early, a high byte where a digit should be,
    // trailing bytes after the fourth number, and a syntax error after an
    // oversized octet.
    send_string("255.0.\t9.256", 1'b1);
    send_string("9 .", 1'b1);
    send_string("7", 1'b1);
    send_string("\x80", 1'b1);
    send_string("3.\x0B4.5.6.", 1'b0);
    send_char(8'h00, 1'b1);
    send_string("256.x", 1'b1);

    // Random strings: mostly well-formed quads, some broken, some noise.
    while (chars_sent < STIMULUS_CHARS) begin
      idle_on = !(chars_sent >= 500 && chars_sent < 650);
      if (!hold_fired && chars_sent >= 300) begin
        hold_request = 1'b1;
        hold_fired = 1'b1;
      end
      text.delete();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        for (int n = 0; n < 4; n++) begin
          blank_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
          repeat (blank_run) text.push_back(pick_blank());
          value = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 9999)
                                              : $urandom_range(0, 255);
          if ($urandom_range(0, 9) == 0) text.push_back(dqip_pkg::CHAR_ZERO);
          numeral = $sformatf("%0d", value);
          for (int k = 0; k < numeral.len(); k++) text.push_back(numeral[k]);
          if (n < 3) text.push_back(dqip_pkg::CHAR_DOT);
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
        end
        // Break about a quarter of the quads.
        if (roll >= 75) begin
          case ($urandom_range(0, 2))
            0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            1: text = text[0:$urandom_range(0, text.size() - 1)];
            default: text.insert($urandom_range(0, text.size() - 1), pick_blank());
          endcase
        end
      end
      send_text();
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    // Drain the remaining results, then keep watching for stray results before the verdict.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fault_count == 0 && tracker.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
